// File: hw/rtl/odo_pkg.sv
// Shared constants, types and functions of the odometry block.
`default_nettype none
package odo_pkg;

   localparam int TRIG_ITERATIONS_DEF = 24;
   localparam logic [31:0] WHEEL_BASE_RESET = 32'd32768;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;
   localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
   localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

   typedef struct packed {
      logic [47:0] odom_x;
      logic [47:0] odom_y;
      logic [31:0] quat_z;
      logic [31:0] quat_w;
      logic [31:0] linear_velocity;
      logic [31:0] angular_velocity;
      logic        zero_interval;
   } odo_rsp_type;

   // Arctangent of 2^-i in Q3.29; the tail is 2^(29-i).
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:    r = 32'd421657428;
         5'd1:    r = 32'd248918915;
         5'd2:    r = 32'd131521918;
         5'd3:    r = 32'd66762579;
         5'd4:    r = 32'd33510843;
         5'd5:    r = 32'd16771758;
         5'd6:    r = 32'd8387925;
         5'd7:    r = 32'd4194219;
         5'd8:    r = 32'd2097141;
         5'd9:    r = 32'd1048575;
         5'd10:   r = 32'd524288;
         5'd30,
         5'd31:   r = 32'd0;
         default: r = 32'd1 << (5'd29 - i);
      endcase
      return r;
   endfunction

   function automatic logic [47:0] sat48(input logic signed [48:0] v);
      logic [47:0] r;
      if (v > 49'sd140737488355327) begin
         r = 48'h7FFF_FFFF_FFFF;
      end else if (v < -49'sd140737488355328) begin
         r = 48'h8000_0000_0000;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/odo_if.sv
// Channel interfaces of the odometry block: request, response, register write.
`default_nettype none
interface odo_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] left_travel;
   logic [31:0] right_travel;
   logic [31:0] time_step;
   modport source (output valid, command, left_travel, right_travel, time_step,
                   input ready);
   modport sink (input valid, command, left_travel, right_travel, time_step,
                 output ready);
endinterface

interface odo_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] odom_x;
   logic [47:0] odom_y;
   logic [31:0] quat_z;
   logic [31:0] quat_w;
   logic [31:0] linear_velocity;
   logic [31:0] angular_velocity;
   logic        zero_interval;
   modport source (output valid, odom_x, odom_y, quat_z, quat_w,
                   linear_velocity, angular_velocity, zero_interval, input ready);
   modport sink (input valid, odom_x, odom_y, quat_z, quat_w,
                 linear_velocity, angular_velocity, zero_interval, output ready);
endinterface

interface odo_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] wheel_base;
   modport source (output valid, wheel_base, input ready);
   modport sink (input valid, wheel_base, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/differential_drive_odometry.sv
// Top level of the differential-drive odometry block: sequencer and state.
// A wheel update runs a bit-serial divide for the heading change (none when the
// wheel base is zero), a CORDIC pass and the multiply and accumulate steps for x
// and y on one shared multiplier; it gives no response. A report runs CORDIC on
// the half heading, then two divides for the velocities (none when the summed
// time is zero), and then waits until the previous response has been taken.
// The request channel is ready only while the sequencer is idle; the register
// port is always ready.
`default_nettype none
module differential_drive_odometry
   import odo_pkg::*;
#(
   parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   odo_req_if.sink   req_ch,
   odo_rsp_if.source rsp_ch,
   odo_csr_if.sink   csr_ch
);
   typedef enum logic [15:0] {
      S_IDLE      = 16'h0001,
      S_UDIV_GO   = 16'h0002,
      S_UDIV_WAIT = 16'h0004,
      S_HEAD      = 16'h0008,
      S_WRAP      = 16'h0010,
      S_TRIG_GO   = 16'h0020,
      S_TRIG_WAIT = 16'h0040,
      S_MUL_X     = 16'h0080,
      S_ACC_X     = 16'h0100,
      S_MUL_Y     = 16'h0200,
      S_ACC_Y     = 16'h0400,
      S_LDIV_GO   = 16'h0800,
      S_LDIV_WAIT = 16'h1000,
      S_ADIV_GO   = 16'h2000,
      S_ADIV_WAIT = 16'h4000,
      S_DONE      = 16'h8000
   } state_type;

   state_type          state_ff, state_in;
   logic               rep_ff, rep_in;
   logic [31:0]        wheel_base_ff;
   logic signed [32:0] diff_ff, diff_in, sum_ff, sum_in;
   logic [31:0]        time_ff, time_in;
   logic signed [33:0] delta_ff, delta_in;
   logic signed [34:0] hraw_ff, hraw_in;
   logic [31:0]        heading_ff, heading_in;
   logic [47:0]        pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [47:0]        shc_ff, shc_in, sdist_ff, sdist_in, stime_ff, stime_in;
   logic signed [64:0] prod_ff, prod_in;
   logic [31:0]        lin_ff, lin_in;
   logic [31:0]        ang_ff, ang_in;
   logic               rsp_valid_ff, rsp_valid_in;
   odo_rsp_type        rsp_ff, rsp_in;

   logic        div_start, div_done, trig_start, trig_done;
   logic [63:0] div_num, quo;
   logic [47:0] div_den;
   logic [31:0] trig_angle, sin_v, cos_v;

   logic [32:0]        diff_mag;
   logic [47:0]        dist_mag, shc_mag;
   logic signed [64:0] rounded;
   logic signed [33:0] pos_step, dist_tmp;
   logic signed [31:0] mul_a;
   logic [48:0]        stime_sum;
   logic [31:0]        qsat;
   logic               qneg;

   odo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (quo)
   );

   odo_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (trig_start),
      .angle  (trig_angle),
      .done   (trig_done),
      .sine   (sin_v),
      .cosine (cos_v)
   );

   assign req_ch.ready = state_ff == S_IDLE;
   assign csr_ch.ready = 1'b1;

   always_comb begin
      diff_mag  = diff_ff[32] ? 33'(-diff_ff) : diff_ff[32:0];
      dist_mag  = sdist_ff[47] ? 48'(-sdist_ff) : sdist_ff;
      shc_mag   = shc_ff[47] ? 48'(-shc_ff) : shc_ff;
      rounded   = prod_ff + 65'sd1073741824;
      pos_step  = rounded[64:31];
      dist_tmp  = {sum_ff[32], sum_ff} + 34'sd1;
      stime_sum = {1'b0, stime_ff} + {17'd0, time_ff};
      mul_a     = $signed(state_ff == S_MUL_X ? cos_v : sin_v);
      prod_in   = mul_a * sum_ff;

      div_start  = state_ff == S_UDIV_GO || state_ff == S_LDIV_GO ||
                   state_ff == S_ADIV_GO;
      trig_start = state_ff == S_TRIG_GO;
      trig_angle = rep_ff ? {1'b0, heading_ff[31:1]} : heading_ff;
      priority if (state_ff == S_UDIV_GO) begin
         div_num = {2'b00, diff_mag, 29'd0};
         div_den = {16'd0, wheel_base_ff};
      end else if (state_ff == S_LDIV_GO) begin
         div_num = {dist_mag, 16'd0};
         div_den = stime_ff;
      end else begin
         div_num = {13'd0, shc_mag, 3'd0};
         div_den = stime_ff;
      end

      // Quotient saturation for the velocity divides; the sign comes from the sum.
      qneg = (state_ff == S_LDIV_WAIT) ? sdist_ff[47] : shc_ff[47];
      if (qneg) begin
         qsat = (quo > 64'd2147483648) ? 32'h8000_0000 : 32'(-quo[31:0]);
      end else begin
         qsat = (quo > 64'd2147483647) ? 32'h7FFF_FFFF : quo[31:0];
      end

      state_in     = state_ff;
      rep_in       = rep_ff;
      diff_in      = diff_ff;
      sum_in       = sum_ff;
      time_in      = time_ff;
      delta_in     = delta_ff;
      hraw_in      = hraw_ff;
      heading_in   = heading_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      shc_in       = shc_ff;
      sdist_in     = sdist_ff;
      stime_in     = stime_ff;
      lin_in       = lin_ff;
      ang_in       = ang_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               rep_in  = req_ch.command == CMD_REPORT;
               diff_in = $signed({req_ch.right_travel[31], req_ch.right_travel}) -
                         $signed({req_ch.left_travel[31], req_ch.left_travel});
               sum_in  = $signed({req_ch.right_travel[31], req_ch.right_travel}) +
                         $signed({req_ch.left_travel[31], req_ch.left_travel});
               time_in = req_ch.time_step;
               state_in = (req_ch.command == CMD_REPORT) ? S_TRIG_GO : S_UDIV_GO;
            end
         end
         S_UDIV_GO: begin
            // A zero wheel base turns any nonzero wheel difference into a full turn.
            if (wheel_base_ff == 32'd0) begin
               if (diff_mag == 33'd0) begin
                  delta_in = '0;
               end else begin
                  delta_in = diff_ff[32] ? -TWO_PI_Q29 : TWO_PI_Q29;
               end
               state_in = S_HEAD;
            end else begin
               state_in = S_UDIV_WAIT;
            end
         end
         S_UDIV_WAIT: begin
            if (div_done) begin
               if (quo > 64'(TWO_PI_Q29)) begin
                  delta_in = diff_ff[32] ? -TWO_PI_Q29 : TWO_PI_Q29;
               end else begin
                  delta_in = diff_ff[32] ? -$signed({2'b00, quo[31:0]}) :
                                           $signed({2'b00, quo[31:0]});
               end
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            hraw_in  = $signed({3'b000, heading_ff}) + {delta_ff[33], delta_ff};
            state_in = S_WRAP;
         end
         S_WRAP: begin
            if (hraw_ff[34]) begin
               heading_in = 32'(hraw_ff + {TWO_PI_Q29[33], TWO_PI_Q29});
            end else if (hraw_ff >= {TWO_PI_Q29[33], TWO_PI_Q29}) begin
               heading_in = 32'(hraw_ff - {TWO_PI_Q29[33], TWO_PI_Q29});
            end else begin
               heading_in = hraw_ff[31:0];
            end
            shc_in   = sat48($signed({shc_ff[47], shc_ff}) +
                             $signed({{15{delta_ff[33]}}, delta_ff}));
            sdist_in = sat48($signed({sdist_ff[47], sdist_ff}) +
                             $signed({{16{dist_tmp[33]}}, dist_tmp[33:1]}));
            stime_in = stime_sum[48] ? 48'hFFFF_FFFF_FFFF : stime_sum[47:0];
            state_in = S_TRIG_GO;
         end
         S_TRIG_GO: state_in = S_TRIG_WAIT;
         S_TRIG_WAIT: begin
            if (trig_done) begin
               if (!rep_ff) begin
                  state_in = S_MUL_X;
               end else if (stime_ff == 48'd0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_LDIV_GO;
               end
            end
         end
         S_MUL_X: state_in = S_ACC_X;
         S_ACC_X: begin
            pos_x_in = sat48($signed({pos_x_ff[47], pos_x_ff}) +
                             $signed({{15{pos_step[33]}}, pos_step}));
            state_in = S_MUL_Y;
         end
         S_MUL_Y: state_in = S_ACC_Y;
         S_ACC_Y: begin
            pos_y_in = sat48($signed({pos_y_ff[47], pos_y_ff}) +
                             $signed({{15{pos_step[33]}}, pos_step}));
            state_in = S_IDLE;
         end
         S_LDIV_GO: state_in = S_LDIV_WAIT;
         S_LDIV_WAIT: begin
            if (div_done) begin
               lin_in   = qsat;
               state_in = S_ADIV_GO;
            end
         end
         S_ADIV_GO: state_in = S_ADIV_WAIT;
         S_ADIV_WAIT: begin
            if (div_done) begin
               ang_in   = qsat;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_in.odom_x           = pos_x_ff;
               rsp_in.odom_y           = pos_y_ff;
               rsp_in.quat_z           = sin_v;
               rsp_in.quat_w           = cos_v;
               rsp_in.zero_interval    = stime_ff == 48'd0;
               rsp_in.linear_velocity  = (stime_ff == 48'd0) ? 32'd0 : lin_ff;
               rsp_in.angular_velocity = (stime_ff == 48'd0) ? 32'd0 : ang_ff;
               rsp_valid_in = 1'b1;
               shc_in       = '0;
               sdist_in     = '0;
               stime_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      sum_ff   <= sum_in;
      time_ff  <= time_in;
      delta_ff <= delta_in;
      hraw_ff  <= hraw_in;
      prod_ff  <= prod_in;
      lin_ff   <= lin_in;
      ang_ff   <= ang_in;
      rsp_ff   <= rsp_in;
      rep_ff   <= rep_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         wheel_base_ff <= WHEEL_BASE_RESET;
         heading_ff    <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         shc_ff        <= '0;
         sdist_ff      <= '0;
         stime_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_ch.valid) begin
            wheel_base_ff <= csr_ch.wheel_base;
         end
         heading_ff   <= heading_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         shc_ff       <= shc_in;
         sdist_ff     <= sdist_in;
         stime_ff     <= stime_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.odom_x           = rsp_ff.odom_x;
   assign rsp_ch.odom_y           = rsp_ff.odom_y;
   assign rsp_ch.quat_z           = rsp_ff.quat_z;
   assign rsp_ch.quat_w           = rsp_ff.quat_w;
   assign rsp_ch.linear_velocity  = rsp_ff.linear_velocity;
   assign rsp_ch.angular_velocity = rsp_ff.angular_velocity;
   assign rsp_ch.zero_interval    = rsp_ff.zero_interval;
endmodule
`default_nettype wire

// File: hw/rtl/odo_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 48-bit divisor.
`default_nettype none
module odo_div
   import odo_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [47:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);
   logic [63:0] num_ff, num_in;
   logic [47:0] rem_ff, rem_in;
   logic [47:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [48:0] rem_sh;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[63]};
      ge      = rem_sh >= {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         rem_in  = ge ? 48'(rem_sh - {1'b0, den_ff}) : rem_sh[47:0];
         num_in  = {num_ff[62:0], ge};
         cnt_in  = cnt_ff - 7'd1;
         done_in = cnt_ff == 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;
endmodule
`default_nettype wire

// File: hw/rtl/odo_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle, giving sin and cos in Q1.30.
`default_nettype none
module odo_cordic
   import odo_pkg::*;
#(
   parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] angle,
   output logic             done,
   output logic [31:0]      sine,
   output logic [31:0]      cosine
);
   typedef enum logic [3:0] {
      C_IDLE = 4'b0001,
      C_PREP = 4'b0010,
      C_ITER = 4'b0100,
      C_POST = 4'b1000
   } cstate_type;

   cstate_type       state_ff, state_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic             neg_ff, neg_in;
   logic [4:0]       i_ff, i_in;
   logic [31:0]      sin_ff, sin_in, cos_ff, cos_in;
   logic             done_ff, done_in;
   logic signed [33:0] a, xs, ys, at, xn, yn;

   always_comb begin
      a        = $signed({2'b00, angle});
      xs       = x_ff >>> i_ff;
      ys       = y_ff >>> i_ff;
      at       = $signed({2'b00, atan_entry(i_ff)});
      xn       = neg_ff ? -x_ff : x_ff;
      yn       = neg_ff ? -y_ff : y_ff;
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      neg_in   = neg_ff;
      i_in     = i_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               z_in     = (a > PI_Q29) ? a - TWO_PI_Q29 : a;
               state_in = C_PREP;
            end
         end
         C_PREP: begin
            // Fold the angle into the right half plane and flip the result later.
            x_in   = GAIN_Q30;
            y_in   = '0;
            i_in   = '0;
            neg_in = 1'b0;
            if (z_ff > HALF_PI_Q29) begin
               z_in   = z_ff - PI_Q29;
               neg_in = 1'b1;
            end else if (z_ff < -HALF_PI_Q29) begin
               z_in   = z_ff + PI_Q29;
               neg_in = 1'b1;
            end
            state_in = C_ITER;
         end
         C_ITER: begin
            if (!z_ff[33]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            i_in = i_ff + 5'd1;
            if (i_ff == 5'(TRIG_ITERATIONS - 1)) begin
               state_in = C_POST;
            end
         end
         C_POST: begin
            priority if (xn > ONE_Q30) cos_in = ONE_Q30[31:0];
            else if (xn < -ONE_Q30) cos_in = 32'(-ONE_Q30);
            else cos_in = xn[31:0];
            priority if (yn > ONE_Q30) sin_in = ONE_Q30[31:0];
            else if (yn < -ONE_Q30) sin_in = 32'(-ONE_Q30);
            else sin_in = yn[31:0];
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
      i_ff   <= i_in;
      sin_ff <= sin_in;
      cos_ff <= cos_in;
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done   = done_ff;
   assign sine   = sin_ff;
   assign cosine = cos_ff;
endmodule
`default_nettype wire

// File: tb/sv/differential_drive_odometry_tb.sv
// Self-checking testbench of the differential-drive odometry block.
`default_nettype none
module differential_drive_odometry_tb
   import odo_pkg::*;
();

   localparam longint MAX48_L = 64'sd140737488355327;
   localparam longint MIN48_L = -64'sd140737488355328;
   localparam longint UMAX48_L = 64'sd281474976710655;
   localparam longint TWO_PI_L = 64'sd3373259426;

   typedef struct packed {
      logic        command;
      logic [31:0] left_travel;
      logic [31:0] right_travel;
      logic [31:0] time_step;
   } odo_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   odo_req_if req_ch();
   odo_rsp_if rsp_ch();
   odo_csr_if csr_ch();

   differential_drive_odometry u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Odometry state as the testbench sees it.
   logic [31:0] base_m;
   longint      heading_q, px, py, turn_sum, dist_sum, time_sum;

   odo_req_type   pending_reqs[$];
   odo_rsp_type   expected_reports[$];
   int            errors = 0;
   int            send_idle_pct = 0;
   int            take_idle_pct = 0;
   logic          req_done = 1'b0;

   function automatic longint floor_shr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint clamp48(longint v);
      if (v > MAX48_L) return MAX48_L;
      if (v < MIN48_L) return MIN48_L;
      return v;
   endfunction

   function automatic longint arctan_step(int i);
      longint heads[11] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                            16771758, 8387925, 4194219, 2097141, 1048575, 524288};
      if (i < 11) return heads[i];
      if (i < 30) return longint'(1) << (29 - i);
      return 0;
   endfunction

   task automatic sin_cos(input longint ang, output longint sn, output longint cs);
      bit     neg;
      longint x, y, z, nx;
      neg = 0;
      x = 652032874;
      y = 0;
      if (ang > 1686629713) ang -= TWO_PI_L;
      if (ang > 843314857) begin
         ang -= 1686629713;
         neg = 1;
      end else if (ang < -843314857) begin
         ang += 1686629713;
         neg = 1;
      end
      z = ang;
      for (int i = 0; i < TRIG_ITERATIONS_DEF && i < 32; i++) begin
         if (z >= 0) begin
            nx = x - floor_shr(y, i);
            y = y + floor_shr(x, i);
            z -= arctan_step(i);
         end else begin
            nx = x + floor_shr(y, i);
            y = y - floor_shr(x, i);
            z += arctan_step(i);
         end
         x = nx;
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      if (x > 1073741824) x = 1073741824;
      if (x < -1073741824) x = -1073741824;
      if (y > 1073741824) y = 1073741824;
      if (y < -1073741824) y = -1073741824;
      sn = y;
      cs = x;
   endtask

   function automatic logic [31:0] velocity(longint num, int sh, longint den);
      logic [63:0] mag, q;
      mag = num < 0 ? 64'(-num) : 64'(num);
      q = (mag << sh) / 64'(den);
      if (num < 0) return q > 64'd2147483648 ? 32'h8000_0000 : 32'(-longint'(q));
      return q > 64'd2147483647 ? 32'h7FFF_FFFF : 32'(q);
   endfunction

   task automatic odometry_predict(input odo_req_type r);
      longint      l, rt, diff, total, delta, h, sn, cs;
      logic [63:0] mag, q;
      odo_rsp_type o;
      if (r.command == CMD_UPDATE) begin
         l = longint'($signed(r.left_travel));
         rt = longint'($signed(r.right_travel));
         diff = rt - l;
         total = l + rt;
         mag = diff < 0 ? 64'(-diff) : 64'(diff);
         if (base_m == 0) q = mag != 0 ? 64'd3373259426 : 64'd0;
         else q = (mag << 29) / 64'(base_m);
         if (q > 64'd3373259426) q = 64'd3373259426;
         delta = diff < 0 ? -longint'(q) : longint'(q);
         h = heading_q + delta;
         if (h < 0) h += TWO_PI_L;
         else if (h >= TWO_PI_L) h -= TWO_PI_L;
         heading_q = h;
         turn_sum = clamp48(turn_sum + delta);
         sin_cos(h, sn, cs);
         px = clamp48(px + floor_shr(cs * total + (longint'(1) << 30), 31));
         py = clamp48(py + floor_shr(sn * total + (longint'(1) << 30), 31));
         dist_sum = clamp48(dist_sum + floor_shr(total + 1, 1));
         time_sum += longint'(r.time_step);
         if (time_sum > UMAX48_L) time_sum = UMAX48_L;
      end else begin
         sin_cos(heading_q >>> 1, sn, cs);
         o.odom_x = px[47:0];
         o.odom_y = py[47:0];
         o.quat_z = sn[31:0];
         o.quat_w = cs[31:0];
         if (time_sum == 0) begin
            o.linear_velocity = '0;
            o.angular_velocity = '0;
            o.zero_interval = 1'b1;
         end else begin
            o.linear_velocity = velocity(dist_sum, 16, time_sum);
            o.angular_velocity = velocity(turn_sum, 3, time_sum);
            o.zero_interval = 1'b0;
         end
         expected_reports.push_back(o);
         turn_sum = 0;
         dist_sum = 0;
         time_sum = 0;
      end
   endtask

   // Driver: a transaction leaves the queue when it is accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_done) begin
         // hold the current transaction
      end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_ch.valid <= 1'b1;
         {req_ch.command, req_ch.left_travel, req_ch.right_travel, req_ch.time_step}
            <= pending_reqs[0];
      end else begin
         req_ch.valid <= 1'b0;
      end
      req_done <= 1'b0;
      rsp_ch.ready <= !reset && $urandom_range(99) >= take_idle_pct;
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         odometry_predict(pending_reqs.pop_front());
         req_done <= 1'b1;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      odo_rsp_type got, exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.odom_x, rsp_ch.odom_y, rsp_ch.quat_z, rsp_ch.quat_w,
                 rsp_ch.linear_velocity, rsp_ch.angular_velocity, rsp_ch.zero_interval};
         if (expected_reports.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected report transaction: %p", got);
         end else begin
            exp_r = expected_reports.pop_front();
            if (got !== exp_r) begin
               errors++;
               if (errors <= 10) $display("Report mismatch: expected %p, got %p", exp_r, got);
            end
         end
      end
   end

   task automatic write_base(input logic [31:0] v);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.wheel_base <= v;
      do @(posedge clock); while (!csr_ch.ready);
      base_m = v;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_reports.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [31:0] travel();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(131072)) - 65536);
         default: return 32'($signed($urandom_range(16384)) - 8192);
      endcase
   endfunction

   task automatic add(input logic c, input logic [31:0] l, input logic [31:0] r,
                      input logic [31:0] t);
      odo_req_type x;
      x = '{c, l, r, t};
      pending_reqs.push_back(x);
   endtask

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(5) == 0) add(CMD_REPORT, $urandom(), $urandom(), $urandom());
         else add(CMD_UPDATE, travel(), travel(),
                  $urandom_range(3) == 0 ? $urandom() : $urandom_range(6554));
      end
      add(CMD_REPORT, 0, 0, 0);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = 1'b0;
      req_ch.left_travel = '0;
      req_ch.right_travel = '0;
      req_ch.time_step = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.wheel_base = '0;
      base_m = WHEEL_BASE_RESET;
      heading_q = 0;
      px = 0;
      py = 0;
      turn_sum = 0;
      dist_sum = 0;
      time_sum = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: report with zero interval, extremes, straight and spinning moves.
      add(CMD_REPORT, 0, 0, 0);
      add(CMD_UPDATE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      add(CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      add(CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      add(CMD_UPDATE, 32'h0000_4000, 32'h0000_8000, 32'd1);
      add(CMD_UPDATE, 32'hFFFF_C000, 32'h0000_0000, 32'd0);
      add(CMD_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add(CMD_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
      add(CMD_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
      add(CMD_REPORT, 0, 0, 0);
      drain();
      write_base(32'd0);
      add(CMD_UPDATE, 32'd5, 32'd9, 32'd100);
      add(CMD_UPDATE, 32'd9, 32'd5, 32'd100);
      add(CMD_UPDATE, 32'd9, 32'd9, 32'd100);
      add(CMD_REPORT, 0, 0, 0);
      drain();
      write_base(32'hFFFF_FFFF);
      add(CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd7);
      add(CMD_REPORT, 0, 0, 0);
      drain();

      send_idle_pct = 34;
      take_idle_pct = 56;
      write_base(32'd1);
      random_phase(80);
      drain();
      write_base(WHEEL_BASE_RESET);
      random_phase(90);
      drain();
      send_idle_pct = 56;
      take_idle_pct = 34;
      write_base($urandom_range(200000, 1));
      random_phase(100);
      drain();
      write_base($urandom());
      random_phase(60);
      drain();
      send_idle_pct = 0;
      take_idle_pct = 0;
      write_base(32'h0002_0000);
      random_phase(150);
      drain();

      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #40000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
